// ----- rtl/pvp_pkg.sv -----
`default_nettype none
package pvp_pkg;

  localparam int unsigned NumChannels = 32;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SqW     = 2 * DiffW;
  localparam int unsigned RootW   = DiffW;
  localparam int unsigned RemW    = RootW + 3;
  localparam int unsigned VecW    = 48;
  localparam int unsigned RotW    = 33;
  localparam int unsigned AngW    = 32;
  localparam int unsigned HeadW   = 16;
  localparam int unsigned WholeW  = RootW - 8;
  localparam int unsigned ProdW   = WholeW + 10;

  localparam int unsigned SqrtSteps   = DiffW;
  localparam int unsigned VecStages   = 8;
  localparam int unsigned RotInit     = 8;
  localparam int unsigned RotFirst    = 9;
  localparam int unsigned IterStages  = 17;

  localparam logic [7:0] MasterVolumeRst = 8'd255;
  localparam logic [7:0] CentrePan       = 8'd127;
  localparam logic [7:0] FullGain        = 8'd255;

  localparam logic [AngW-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [AngW-1:0] HalfTurn    = 32'h8000_0000;

  localparam logic signed [RotW-1:0] InvGain = 33'sd652032874;
  localparam logic signed [RotW-1:0] OneQ30  = 33'sd1073741824;

  localparam logic [11:0] PanScale  = 12'd2559;
  localparam logic [27:0] Recip255  = 28'd134744073;
  localparam logic [15:0] Div5Mul   = 16'd52429;

  typedef enum logic [0:0] {
    RegMasterVolume = 1'b0,
    RegStereoEnable = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [4:0]              ch;
    logic                    loc;
    logic                    hz;
    logic                    pan_en;
    logic [HeadW-1:0]        head;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic [SqW-1:0]          sqx;
    logic [SqW-1:0]          sqy;
    logic [SqW-1:0]          sqz;
    logic [SqW-1:0]          sq;
    logic [RemW-1:0]         rem;
    logic [RootW-1:0]        root;
    logic signed [VecW-1:0]  vx;
    logic signed [VecW-1:0]  vy;
    logic [AngW-1:0]         acc;
    logic signed [RotW-1:0]  rx;
    logic signed [RotW-1:0]  ry;
    logic signed [RotW-1:0]  rz;
    logic [ProdW-1:0]        prod;
    logic [11:0]             n12;
    logic [7:0]              level;
    logic [7:0]              right;
    logic [7:0]              left;
    logic [7:0]              vol;
  } pipe_t;

  function automatic logic [AngW-1:0] arc_of(input int unsigned i);
    logic [AngW-1:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10680862;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      default: a = 32'd20861;
    endcase
    return a;
  endfunction

  // up to two root digits, two bearing steps and two sine steps, by stage number
  function automatic pipe_t iter_stage(input pipe_t p, input int unsigned j);
    pipe_t                   q;
    int unsigned             s;
    logic [RemW-1:0]         rsh;
    logic [RemW-1:0]         trial;
    logic signed [VecW-1:0]  vx_n;
    logic signed [VecW-1:0]  vy_n;
    logic signed [RotW-1:0]  rx_n;
    logic signed [RotW-1:0]  ry_n;
    logic signed [RotW-1:0]  arc_s;
    logic [AngW-1:0]         ang;
    q = p;
    for (int k = 0; k < 2; k++) begin
      s = 2 * j + k;
      if (s < SqrtSteps) begin
        rsh   = {q.rem[RemW-3:0], q.sq[SqW-1 -: 2]};
        q.sq  = {q.sq[SqW-3:0], 2'b00};
        trial = {1'b0, q.root, 2'b01};
        if (rsh >= trial) begin
          q.rem  = rsh - trial;
          q.root = {q.root[RootW-2:0], 1'b1};
        end else begin
          q.rem  = rsh;
          q.root = {q.root[RootW-2:0], 1'b0};
        end
      end
      if (j < VecStages) begin
        if (q.vy < 0) begin
          vx_n  = q.vx - (q.vy >>> s);
          vy_n  = q.vy + (q.vx >>> s);
          q.acc = q.acc - arc_of(s);
        end else begin
          vx_n  = q.vx + (q.vy >>> s);
          vy_n  = q.vy - (q.vx >>> s);
          q.acc = q.acc + arc_of(s);
        end
        q.vx = vx_n;
        q.vy = vy_n;
      end
      if (j >= RotFirst) begin
        s     = 2 * (j - RotFirst) + k;
        arc_s = $signed({1'b0, arc_of(s)});
        if (q.rz >= 0) begin
          rx_n = q.rx - (q.ry >>> s);
          ry_n = q.ry + (q.rx >>> s);
          q.rz = q.rz - arc_s;
        end else begin
          rx_n = q.rx + (q.ry >>> s);
          ry_n = q.ry - (q.rx >>> s);
          q.rz = q.rz + arc_s;
        end
        q.rx = rx_n;
        q.ry = ry_n;
      end
    end
    if (j == RotInit) begin
      ang = 32'h0 - q.acc - {q.head, 16'h0};
      // fold the back half onto the front half
      if ((ang - QuarterTurn) < HalfTurn) begin
        ang = HalfTurn - ang;
      end
      q.rz = $signed({ang[AngW-1], ang});
      q.rx = InvGain;
      q.ry = '0;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/positional_volume_pan_unit.sv -----
`default_nettype none
// channel  direction  handshake               payload
// in       request    in_valid_i/in_stall_o   channel_i .. listener_heading_i
// out      result     out_valid_o/out_stall_i out_channel_o .. right_gain_o
// cfg      write      cfg_we_i                cfg_idx_i, cfg_wdata_i
// one request per cycle while the result is not stalled
// pipeline length is set by the 25-digit root and two 16-step cordic units, two steps per stage
// a request for a channel at or above the channel count gives no result
// reset clears the valid bits and loads volume 255 and stereo on
// a stalled result freezes the whole pipeline, empty stages included
module positional_volume_pan_unit #(
  parameter int unsigned NumChannels = pvp_pkg::NumChannels
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [4:0]  channel_i,
  input  wire logic        has_location_i,
  input  wire logic [23:0] source_x_i,
  input  wire logic [23:0] source_y_i,
  input  wire logic [23:0] source_z_i,
  input  wire logic [23:0] listener_x_i,
  input  wire logic [23:0] listener_y_i,
  input  wire logic [23:0] listener_z_i,
  input  wire logic [15:0] listener_heading_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [4:0]  out_channel_o,
  output      logic [7:0]  volume_o,
  output      logic [7:0]  left_gain_o,
  output      logic [7:0]  right_gain_o
);

  localparam int unsigned IterBase  = 3;
  localparam int unsigned MulStage  = IterBase + pvp_pkg::IterStages;
  localparam int unsigned NumStages = MulStage + 3;
  localparam int unsigned LastStage = NumStages - 1;

  logic [7:0]     mv_q;
  logic           stereo_q;
  logic           en;
  logic           vld_q [NumStages];
  pvp_pkg::pipe_t st_q  [NumStages];
  pvp_pkg::pipe_t st_d  [NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q     <= pvp_pkg::MasterVolumeRst;
      stereo_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (pvp_pkg::reg_idx_e'(cfg_idx_i))
        pvp_pkg::RegMasterVolume: mv_q     <= cfg_wdata_i;
        pvp_pkg::RegStereoEnable: stereo_q <= cfg_wdata_i[0];
      endcase
    end
  end

  assign en         = !(vld_q[LastStage] && out_stall_i);
  assign in_stall_o = !en;

  // offsets
  always_comb begin
    st_d[0]      = '0;
    st_d[0].ch   = channel_i;
    st_d[0].loc  = has_location_i;
    st_d[0].head = listener_heading_i;
    st_d[0].dx   = $signed({listener_x_i[23], listener_x_i}) -
                   $signed({source_x_i[23], source_x_i});
    st_d[0].dy   = $signed({listener_y_i[23], listener_y_i}) -
                   $signed({source_y_i[23], source_y_i});
    st_d[0].dz   = $signed({listener_z_i[23], listener_z_i}) -
                   $signed({source_z_i[23], source_z_i});
  end

  // squares and bearing start vector
  always_comb begin
    logic signed [pvp_pkg::SqW-1:0]  mx;
    logic signed [pvp_pkg::SqW-1:0]  my;
    logic signed [pvp_pkg::SqW-1:0]  mz;
    logic signed [pvp_pkg::VecW-1:0] vx0;
    logic signed [pvp_pkg::VecW-1:0] vy0;
    st_d[1]     = st_q[0];
    mx          = st_q[0].dx * st_q[0].dx;
    my          = st_q[0].dy * st_q[0].dy;
    mz          = st_q[0].dz * st_q[0].dz;
    st_d[1].sqx = mx;
    st_d[1].sqy = my;
    st_d[1].sqz = mz;
    st_d[1].hz  = (st_q[0].dx != '0) || (st_q[0].dz != '0);
    vy0 = {{3{st_q[0].dx[pvp_pkg::DiffW-1]}}, st_q[0].dx, 20'h0};
    vx0 = {{3{st_q[0].dz[pvp_pkg::DiffW-1]}}, st_q[0].dz, 20'h0};
    if (vx0 < 0) begin
      st_d[1].vx  = -vx0;
      st_d[1].vy  = -vy0;
      st_d[1].acc = pvp_pkg::HalfTurn;
    end else begin
      st_d[1].vx  = vx0;
      st_d[1].vy  = vy0;
      st_d[1].acc = '0;
    end
  end

  always_comb begin
    st_d[2]      = st_q[1];
    st_d[2].sq   = st_q[1].sqx + st_q[1].sqy + st_q[1].sqz;
    st_d[2].rem  = '0;
    st_d[2].root = '0;
  end

  for (genvar gi = 0; gi < pvp_pkg::IterStages; gi++) begin : g_iter
    always_comb begin
      st_d[IterBase+gi] = pvp_pkg::iter_stage(st_q[IterBase+gi-1], gi);
    end
  end

  // attenuation product and pan scaling
  always_comb begin
    logic [pvp_pkg::WholeW-1:0] whole;
    logic [9:0]                 mv3;
    logic signed [pvp_pkg::RotW-1:0] ys;
    logic signed [pvp_pkg::RotW-1:0] u;
    logic [43:0]                num;
    st_d[MulStage]        = st_q[MulStage-1];
    whole                 = st_q[MulStage-1].root[pvp_pkg::RootW-1:8];
    mv3                   = {2'b00, mv_q} + {1'b0, mv_q, 1'b0};
    st_d[MulStage].prod   = pvp_pkg::ProdW'(whole) * pvp_pkg::ProdW'(mv3);
    ys = st_q[MulStage-1].ry;
    if (ys > pvp_pkg::OneQ30) begin
      ys = pvp_pkg::OneQ30;
    end
    if (ys < -pvp_pkg::OneQ30) begin
      ys = -pvp_pkg::OneQ30;
    end
    u   = ys + pvp_pkg::OneQ30;
    num = 44'(pvp_pkg::PanScale) * 44'(u[31:0]);
    st_d[MulStage].n12    = num[43:32];
    st_d[MulStage].pan_en = stereo_q && st_q[MulStage-1].loc && st_q[MulStage-1].hz;
  end

  // divide by 255 and by 5 through reciprocals
  always_comb begin
    logic [54:0] mprod;
    logic [19:0] att;
    logic [27:0] d5;
    st_d[MulStage+1] = st_q[MulStage];
    mprod = 55'(st_q[MulStage].prod) * 55'(pvp_pkg::Recip255);
    att   = mprod[54:35];
    if (!st_q[MulStage].loc) begin
      st_d[MulStage+1].level = mv_q;
    end else if (att < {12'h0, mv_q}) begin
      st_d[MulStage+1].level = mv_q - att[7:0];
    end else begin
      st_d[MulStage+1].level = '0;
    end
    d5 = 28'(st_q[MulStage].n12) * 28'(pvp_pkg::Div5Mul);
    st_d[MulStage+1].right = st_q[MulStage].pan_en ? d5[25:18] : pvp_pkg::CentrePan;
  end

  // volume scaled to 0..128
  always_comb begin
    logic [7:0] q0;
    logic [8:0] r;
    st_d[LastStage]      = st_q[LastStage-1];
    q0 = {1'b0, st_q[LastStage-1].level[7:1]};
    r  = {1'b0, st_q[LastStage-1].level[0], 7'h0} + {1'b0, q0};
    st_d[LastStage].vol  = (r >= 9'd255) ? q0 + 8'd1 : q0;
    st_d[LastStage].left = pvp_pkg::FullGain - st_q[LastStage-1].right;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i && (32'(channel_i) < NumChannels);
      for (int i = 1; i < NumStages; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumStages; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign out_valid_o   = vld_q[LastStage];
  assign out_channel_o = st_q[LastStage].ch;
  assign volume_o      = st_q[LastStage].vol;
  assign left_gain_o   = st_q[LastStage].left;
  assign right_gain_o  = st_q[LastStage].right;

endmodule
`default_nettype wire
